// ----- rtl/mgc_pkg.sv -----
// ----------------------------------------------------------------------------
// mgc_pkg
// Shared types, widths and the microcode table for the gyro correction block.
// ----------------------------------------------------------------------------
package mgc_pkg;

  localparam int Q_W       = 16;   // quaternion / accel, Q1.14
  localparam int RATE_W    = 24;   // gyro rates, Q7.16
  localparam int DT_W      = 24;   // time step, Q0.24
  localparam int GAIN_W    = 24;   // Kp / Ki, Q8.16
  localparam int G_W       = 34;   // gravity estimate, Q.28
  localparam int E_W       = 24;   // error vector, Q.16
  localparam int INT_W     = 32;   // integrals, Q15.16
  localparam int TMP_W     = 32;   // Ki*e, P term, integral step
  localparam int MA_W      = GAIN_W + 1;
  localparam int MB_W      = G_W;
  localparam int ACC_W     = MA_W + MB_W;
  localparam int NUM_STEPS = 34;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam int AXES      = 3;
  localparam int IDX_W     = $clog2(AXES);
  localparam int IN_W      = 208;
  localparam int OUT_W     = 72;
  localparam int CFG_IDX_W = 2;

  localparam int SH_E    = 26;     // Q.42 -> Q.16
  localparam int SH_GAIN = 16;     // Q.32 -> Q.16
  localparam int SH_DT   = 24;     // Q.40 -> Q.16

  localparam logic [CFG_IDX_W-1:0] CFG_KP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KI = CFG_IDX_W'(1);
  localparam logic [GAIN_W-1:0]    KP_RESET = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]    KI_RESET = '0;

  localparam logic [IDX_W-1:0] AX_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] AX_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] AX_Z = IDX_W'(2);

  typedef enum logic [3:0] {
    A_Q0, A_Q1, A_Q2, A_Q3, A_AX, A_AY, A_AZ, A_KP, A_KI, A_DT
  } a_sel_t;

  typedef enum logic [3:0] {
    B_Q0, B_Q1, B_Q2, B_Q3, B_G0, B_G1, B_G2, B_E0, B_E1, B_E2, B_KIE
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_G, WB_E, WB_KIE, WB_P, WB_STEP, WB_INT, WB_OUT
  } wb_op_t;

  typedef struct packed {
    a_sel_t             a_sel;
    b_sel_t             b_sel;
    acc_op_t            acc_op;
    wb_op_t             wb_op;
    logic [IDX_W-1:0]   wb_idx;
    logic               wb_dbl;   // write back twice the sum
  } ucode_t;

  typedef struct packed {
    logic   capture;   // latch the accepted input word
    logic   out_load;  // move finished results to the output register
    ucode_t uc;
  } mgc_cmd_t;

  localparam ucode_t UC_NOP = '{A_Q0, B_Q0, ACC_HOLD, WB_NONE, AX_X, 1'b0};

  function automatic ucode_t uc_mul(input a_sel_t a, input b_sel_t b, input acc_op_t op,
                                    input wb_op_t wb, input logic [IDX_W-1:0] idx,
                                    input logic dbl);
    ucode_t u;
    u.a_sel  = a;
    u.b_sel  = b;
    u.acc_op = op;
    u.wb_op  = wb;
    u.wb_idx = idx;
    u.wb_dbl = dbl;
    return u;
  endfunction

  function automatic ucode_t uc_wb(input wb_op_t wb, input logic [IDX_W-1:0] idx);
    return uc_mul(A_Q0, B_Q0, ACC_HOLD, wb, idx, 1'b0);
  endfunction

  // A product issued at a step is registered in prod_r and then summed into
  // acc_r, so a write back of that sum is placed after both registers.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    case (step)
      // gravity: gx = 2(q1q3 - q0q2), gy = 2(q0q1 + q2q3), gz = q0^2-q1^2-q2^2+q3^2
      6'd0:  u = uc_mul(A_Q1, B_Q3, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd1:  u = uc_mul(A_Q0, B_Q2, ACC_SUB,  WB_NONE, AX_X, 1'b0);
      6'd2:  u = uc_mul(A_Q0, B_Q1, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd3:  u = uc_mul(A_Q2, B_Q3, ACC_ADD,  WB_G,    AX_X, 1'b1);
      6'd4:  u = uc_mul(A_Q0, B_Q0, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd5:  u = uc_mul(A_Q1, B_Q1, ACC_SUB,  WB_G,    AX_Y, 1'b1);
      6'd6:  u = uc_mul(A_Q2, B_Q2, ACC_SUB,  WB_NONE, AX_X, 1'b0);
      6'd7:  u = uc_mul(A_Q3, B_Q3, ACC_ADD,  WB_NONE, AX_X, 1'b0);
      // error e = a x g, z first since it only needs gx, gy
      6'd8:  u = uc_mul(A_AX, B_G1, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd9:  u = uc_mul(A_AY, B_G0, ACC_SUB,  WB_G,    AX_Z, 1'b0);
      6'd10: u = uc_mul(A_AY, B_G2, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd11: u = uc_mul(A_AZ, B_G1, ACC_SUB,  WB_E,    AX_Z, 1'b0);
      6'd12: u = uc_mul(A_AZ, B_G0, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd13: u = uc_mul(A_AX, B_G2, ACC_SUB,  WB_E,    AX_X, 1'b0);
      // x axis PI
      6'd14: u = uc_mul(A_KI, B_E0, ACC_LOAD, WB_NONE, AX_X, 1'b0);
      6'd15: u = uc_mul(A_KP, B_E0, ACC_LOAD, WB_E,    AX_Y, 1'b0);
      6'd16: u = uc_wb(WB_KIE, AX_X);
      6'd17: u = uc_mul(A_DT, B_KIE, ACC_LOAD, WB_P,   AX_X, 1'b0);
      6'd18: u = UC_NOP;
      6'd19: u = uc_wb(WB_STEP, AX_X);
      // y axis PI, overlapped with the x axis tail
      6'd20: u = uc_mul(A_KI, B_E1, ACC_LOAD, WB_INT,  AX_X, 1'b0);
      6'd21: u = uc_mul(A_KP, B_E1, ACC_LOAD, WB_OUT,  AX_X, 1'b0);
      6'd22: u = uc_wb(WB_KIE, AX_Y);
      6'd23: u = uc_mul(A_DT, B_KIE, ACC_LOAD, WB_P,   AX_Y, 1'b0);
      6'd24: u = UC_NOP;
      6'd25: u = uc_wb(WB_STEP, AX_Y);
      // z axis PI
      6'd26: u = uc_mul(A_KI, B_E2, ACC_LOAD, WB_INT,  AX_Y, 1'b0);
      6'd27: u = uc_mul(A_KP, B_E2, ACC_LOAD, WB_OUT,  AX_Y, 1'b0);
      6'd28: u = uc_wb(WB_KIE, AX_Z);
      6'd29: u = uc_mul(A_DT, B_KIE, ACC_LOAD, WB_P,   AX_Z, 1'b0);
      6'd30: u = UC_NOP;
      6'd31: u = uc_wb(WB_STEP, AX_Z);
      6'd32: u = uc_wb(WB_INT, AX_Z);
      6'd33: u = uc_wb(WB_OUT, AX_Z);
      default: u = UC_NOP;
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/mgc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mgc_ctrl
// Sequencer: accepts a word, steps through the microcode, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module mgc_ctrl import mgc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output mgc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the previous word to leave the output register
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready    = (state_r == ST_IDLE);
  assign out_tvalid   = out_valid_r;
  assign cmd.capture  = in_tready && in_tvalid;
  assign cmd.out_load = out_load;
  assign cmd.uc       = (state_r == ST_RUN) ? ucode(step_r) : UC_NOP;

endmodule

// ----- rtl/mgc_datapath.sv -----
// ----------------------------------------------------------------------------
// mgc_datapath
// Shared 25x34 multiplier, 59-bit accumulator, rounding write-back,
// integral state, gain registers and the output register.
// ----------------------------------------------------------------------------
module mgc_datapath import mgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mgc_cmd_t             cmd,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  output logic [OUT_W-1:0]     out_tdata
);

  localparam int OSUM_W = TMP_W + 2;

  // latched input word
  logic signed [Q_W-1:0]    q_r [4];
  logic signed [Q_W-1:0]    a_r [AXES];
  logic signed [RATE_W-1:0] rate_r [AXES];
  logic [DT_W-1:0]          dt_r;

  logic [GAIN_W-1:0]        kp_r, ki_r;

  logic signed [G_W-1:0]    g_r [AXES];
  logic signed [E_W-1:0]    e_r [AXES];
  logic signed [TMP_W-1:0]  kie_r, p_r, step_r;
  logic signed [INT_W-1:0]  integ_r [AXES];
  logic signed [RATE_W-1:0] res_r [AXES];
  logic [RATE_W-1:0]        out_r [AXES];

  logic signed [MA_W-1:0]   opa;
  logic signed [MB_W-1:0]   opb;
  logic signed [ACC_W-1:0]  prod_r, acc_r, acc_nxt;
  acc_op_t                  acc_op_r;

  logic signed [ACC_W-1:0]  half, rnd_sum, rnd_val, g_val;
  logic signed [INT_W:0]    int_sum;
  logic signed [INT_W-1:0]  int_sat;
  logic signed [OSUM_W-1:0] out_sum;
  logic signed [RATE_W-1:0] out_sat;
  logic [OSUM_W-RATE_W:0]   out_top;
  ucode_t                   uc;
  logic [IDX_W-1:0]         wi;

  assign uc = cmd.uc;
  assign wi = uc.wb_idx;

  // input capture, fields from the lowest bit up
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r[0]    <= in_tdata[15:0];
      q_r[1]    <= in_tdata[31:16];
      q_r[2]    <= in_tdata[47:32];
      q_r[3]    <= in_tdata[63:48];
      a_r[0]    <= in_tdata[79:64];
      a_r[1]    <= in_tdata[95:80];
      a_r[2]    <= in_tdata[111:96];
      rate_r[0] <= in_tdata[135:112];
      rate_r[1] <= in_tdata[159:136];
      rate_r[2] <= in_tdata[183:160];
      dt_r      <= in_tdata[207:184];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KP:  kp_r <= cfg_wdata;
        CFG_KI:  ki_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier operands
  always_comb begin
    case (uc.a_sel)
      A_Q0:    opa = MA_W'(q_r[0]);
      A_Q1:    opa = MA_W'(q_r[1]);
      A_Q2:    opa = MA_W'(q_r[2]);
      A_Q3:    opa = MA_W'(q_r[3]);
      A_AX:    opa = MA_W'(a_r[0]);
      A_AY:    opa = MA_W'(a_r[1]);
      A_AZ:    opa = MA_W'(a_r[2]);
      A_KP:    opa = $signed({1'b0, kp_r});
      A_KI:    opa = $signed({1'b0, ki_r});
      A_DT:    opa = $signed({1'b0, dt_r});
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (uc.b_sel)
      B_Q0:    opb = MB_W'(q_r[0]);
      B_Q1:    opb = MB_W'(q_r[1]);
      B_Q2:    opb = MB_W'(q_r[2]);
      B_Q3:    opb = MB_W'(q_r[3]);
      B_G0:    opb = g_r[0];
      B_G1:    opb = g_r[1];
      B_G2:    opb = g_r[2];
      B_E0:    opb = MB_W'(e_r[0]);
      B_E1:    opb = MB_W'(e_r[1]);
      B_E2:    opb = MB_W'(e_r[2]);
      B_KIE:   opb = MB_W'(kie_r);
      default: opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  always_comb begin
    case (acc_op_r)
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      ACC_SUB:  acc_nxt = acc_r - prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= ACC_HOLD;
    end else begin
      acc_op_r <= uc.acc_op;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up: add half an LSB of the target, then arithmetic shift
  always_comb begin
    half = '0;
    case (uc.wb_op)
      WB_E:    half[SH_E-1]    = 1'b1;
      WB_STEP: half[SH_DT-1]   = 1'b1;
      default: half[SH_GAIN-1] = 1'b1;
    endcase
    rnd_sum = acc_r + half;
    case (uc.wb_op)
      WB_E:    rnd_val = rnd_sum >>> SH_E;
      WB_STEP: rnd_val = rnd_sum >>> SH_DT;
      default: rnd_val = rnd_sum >>> SH_GAIN;
    endcase
  end

  assign g_val = uc.wb_dbl ? (acc_r <<< 1) : acc_r;

  // integral update, saturated to 32 bits
  always_comb begin
    int_sum = (INT_W+1)'(integ_r[wi]) + (INT_W+1)'(step_r);
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_sat = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      int_sat = int_sum[INT_W-1:0];
    end
  end

  // rate + P + integral, saturated to the output range
  always_comb begin
    out_sum = OSUM_W'(rate_r[wi]) + OSUM_W'(p_r) + OSUM_W'(integ_r[wi]);
    out_top = out_sum[OSUM_W-1:RATE_W-1];
    if ((&out_top) || !(|out_top)) begin
      out_sat = out_sum[RATE_W-1:0];
    end else begin
      out_sat = out_sum[OSUM_W-1] ? {1'b1, {(RATE_W-1){1'b0}}}
                                  : {1'b0, {(RATE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    case (uc.wb_op)
      WB_G:    g_r[wi]   <= g_val[G_W-1:0];
      WB_E:    e_r[wi]   <= rnd_val[E_W-1:0];
      WB_KIE:  kie_r     <= rnd_val[TMP_W-1:0];
      WB_P:    p_r       <= rnd_val[TMP_W-1:0];
      WB_STEP: step_r    <= rnd_val[TMP_W-1:0];
      WB_OUT:  res_r[wi] <= out_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        integ_r[i] <= '0;
      end
    end else if (uc.wb_op == WB_INT) begin
      integ_r[wi] <= int_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < AXES; i++) begin
        out_r[i] <= res_r[i];
      end
    end
  end

  assign out_tdata = {out_r[2], out_r[1], out_r[0]};

endmodule

// ----- rtl/mahony_gyro_correction.sv -----
// ----------------------------------------------------------------------------
// mahony_gyro_correction
// Mahony complementary filter gyro correction step in fixed point.
// ----------------------------------------------------------------------------
// One word in gives one word out. The block takes a new input word only when
// idle; from the accepting edge it runs 34 microcode steps through a single
// shared 25x34 multiplier and a 59-bit accumulator, then loads the output
// register and returns to idle; it takes no new word before the last one is
// through. A finished result waits in the output register while the next
// word is already being computed; a stall on the output side only holds the
// block once the following result is ready. The user must write Kp and Ki
// through the cfg port only while no word is in flight; the block itself
// does not enforce this (index 0 = Kp, index 1 = Ki, others ignored). The
// three integrals reset to zero and saturate at the signed 32-bit range.
// ----------------------------------------------------------------------------
module mahony_gyro_correction import mgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
  // rate_x_in, rate_y_in, rate_z_in, time_step
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // rate_x_out, rate_y_out, rate_z_out
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata
);

  mgc_cmd_t cmd;

  mgc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mgc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule

// ----- rtl/mgc_checker.sv -----
// ----------------------------------------------------------------------------
// mgc_checker
// Port-level checks for the gyro correction block, bound to the top level.
// ----------------------------------------------------------------------------
module mgc_checker import mgc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a word is busy in the sequencer right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted word");

  // and still busy on the last cycle before the result is loaded
  a_busy_full_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##35 !in_tready)
    else $error("input taken before the previous word finished");

  // a new result shows up exactly when the sequencer goes idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the sequencer was busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word dropped or changed");

endmodule

bind mahony_gyro_correction mgc_checker u_mgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
